@@ rtl/lifb_pkg.sv @@
// shared codes, states and field widths of the lockstep input frame buffer
package lifb_pkg;

   localparam logic [1:0] OP_REMOTE = 2'd0;
   localparam logic [1:0] OP_LOCAL  = 2'd1;
   localparam logic [1:0] OP_DROP   = 2'd2;
   localparam logic [1:0] OP_FRAME  = 2'd3;

   localparam logic [1:0] KIND_ACCEPT = 2'd0;
   localparam logic [1:0] KIND_REJECT = 2'd1;
   localparam logic [1:0] KIND_STALL  = 2'd2;
   localparam logic [1:0] KIND_PAD    = 2'd3;

   localparam logic [2:0] REG_PLAYER_COUNT = 3'd0;
   localparam logic [2:0] REG_LOCAL_SLOT   = 3'd1;
   localparam logic [2:0] REG_IS_HOST      = 3'd2;
   localparam logic [2:0] REG_DROP_AFTER   = 3'd3;
   localparam logic [2:0] REG_GIVEUP_AFTER = 3'd4;

   localparam logic [2:0] NO_STALL = 3'd7;

   localparam logic [2:0]  RST_PLAYER_COUNT = 3'd1;
   localparam logic [31:0] RST_DROP_AFTER   = 32'd10000000;
   localparam logic [31:0] RST_GIVEUP_AFTER = 32'd15000000;

   localparam int ENTRY_W = 64;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_CHK_RD,
      ST_CHK_EV,
      ST_PAD_RD,
      ST_PAD_EV
   } state_type;

endpackage

@@ rtl/lifb_ram.sv @@
// generic single-port-write, registered-read ram
module lifb_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end

endmodule

@@ rtl/lockstep_input_frame_buffer.sv @@
// lockstep input frame buffer: per-slot frame-tagged input rings with a frame sequencer
//
// Remote inputs, local inputs and drop notices each give one result in the cycle after
// start. A frame request walks the active slots through the ring memory, a read then a
// check state per slot, and stops with a stall result at the first remote slot with its
// input missing and no timeout run out; else it reads out min(MAX_SLOTS,4) pads, a read
// then an output state per pad, as the memory has one read port. Results appear for one
// cycle each on rsp_valid and cannot be held off. After reset the block is busy for a
// clearing pass of RING_DEPTH+INPUT_LAG writes per slot; configuration writes are taken meanwhile.
module lockstep_input_frame_buffer #(
   parameter int RING_DEPTH = 128,
   parameter int INPUT_LAG  = 2,
   parameter int MAX_SLOTS  = 4
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [1:0]         req_op,
   input  logic [1:0]         req_slot,
   input  logic [31:0]        req_frame,
   input  logic [15:0]        req_button,
   input  logic signed [7:0]  req_stick_x,
   input  logic signed [7:0]  req_stick_y,
   input  logic               req_host_msg,
   input  logic [31:0]        req_now_time,
   output logic               rsp_valid,
   output logic [1:0]         rsp_kind,
   output logic [1:0]         rsp_out_slot,
   output logic [31:0]        rsp_out_frame,
   output logic [15:0]        rsp_pad_button,
   output logic signed [7:0]  rsp_pad_stick_x,
   output logic signed [7:0]  rsp_pad_stick_y,
   output logic               rsp_no_response,
   output logic               rsp_last,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_wdata
);
   import lifb_pkg::*;

   localparam int IW = $clog2(RING_DEPTH);
   localparam int SW = $clog2(MAX_SLOTS);
   localparam int CW = $clog2(MAX_SLOTS + 1);
   localparam int TOTAL = MAX_SLOTS * RING_DEPTH;
   localparam int AW = $clog2(TOTAL);
   localparam int NW = $clog2(RING_DEPTH + INPUT_LAG + 1);
   localparam int NPADS = (MAX_SLOTS < 4) ? MAX_SLOTS : 4;
   localparam int LAG_MOD = INPUT_LAG % RING_DEPTH;
   localparam logic [31:0] HALF = 32'(RING_DEPTH / 2);
   localparam logic [31:0] LAG32 = 32'(INPUT_LAG);
   localparam logic [AW-1:0] DEPTH_A = AW'(RING_DEPTH);
   localparam logic [IW:0] DEPTH_U = (IW + 1)'(RING_DEPTH);
   localparam logic signed [IW+1:0] DEPTH_S = (IW + 2)'(RING_DEPTH);
   localparam logic [NW-1:0] DEPTH_N = NW'(RING_DEPTH);
   localparam logic [NW-1:0] CLR_LAST = NW'(RING_DEPTH + INPUT_LAG - 1);
   localparam logic [SW-1:0] SLOT_LAST = SW'(MAX_SLOTS - 1);
   localparam logic [CW-1:0] PAD_LAST = CW'(NPADS - 1);
   localparam logic [3:0] MAX_S4 = 4'(MAX_SLOTS);

   function automatic logic [AW-1:0] ent_addr(input logic [SW-1:0] s, input logic [IW-1:0] i);
      return AW'(s) * DEPTH_A + AW'(i);
   endfunction

   state_type state_ff, state_in;
   logic [31:0] cur_ff, cur_in;
   logic [IW-1:0] cidx_ff, cidx_in;
   logic [MAX_SLOTS-1:0] mask_ff, mask_in;
   logic [31:0] dfrom_ff [MAX_SLOTS];
   logic [31:0] dfrom_in [MAX_SLOTS];
   logic [2:0] stall_ff, stall_in;
   logic [31:0] sstart_ff, sstart_in;
   logic [31:0] lhost_ff, lhost_in;
   logic [2:0] pc_ff, pc_in;
   logic [1:0] ls_ff, ls_in;
   logic host_ff, host_in;
   logic [31:0] dafter_ff, dafter_in;
   logic [31:0] gafter_ff, gafter_in;
   logic [CW-1:0] s_ff, s_in;
   logic [SW-1:0] cslot_ff, cslot_in;
   logic [NW-1:0] cn_ff, cn_in;
   logic [IW-1:0] cci_ff, cci_in;
   logic [31:0] now_ff, now_in;

   logic rv_ff, rv_in;
   logic [1:0] rkind_ff, rkind_in;
   logic [1:0] rslot_ff, rslot_in;
   logic [31:0] rframe_ff, rframe_in;
   logic [31:0] rval_ff, rval_in;
   logic rnores_ff, rnores_in;
   logic rlast_ff, rlast_in;

   logic mem_we;
   logic [AW-1:0] mem_waddr, mem_raddr;
   logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

   logic [CW-1:0] players;
   logic [3:0] pc_ext;
   logic [SW-1:0] sl;
   logic [31:0] tag;
   logic drop_now;
   logic [31:0] d;
   logic signed [IW+1:0] t;
   logic [IW-1:0] ridx;
   logic [IW:0] lsum;
   logic [IW-1:0] lidx;
   logic [31:0] st_eff;
   logic [31:0] req_packed;
   logic ok;

   lifb_ram #(.WIDTH(ENTRY_W), .DEPTH(TOTAL)) u_ram (
      .clock (clock),
      .we    (mem_we),
      .waddr (mem_waddr),
      .wdata (mem_wdata),
      .raddr (mem_raddr),
      .rdata (mem_rdata)
   );

   always_comb begin
      pc_ext = {1'b0, pc_ff};
      players = (pc_ext > MAX_S4) ? CW'(MAX_SLOTS) : CW'(pc_ext);
      sl = SW'(s_ff);
      tag = mem_rdata[63:32];
      drop_now = mask_ff[sl] && (cur_ff >= dfrom_ff[sl]);
      d = req_frame - cur_ff;
      t = $signed({2'b00, cidx_ff}) + $signed(d[IW+1:0]);
      if (t < 0) begin
         t = t + DEPTH_S;
      end else if (t >= DEPTH_S) begin
         t = t - DEPTH_S;
      end
      ridx = IW'(t);
      lsum = {1'b0, cidx_ff} + (IW + 1)'(LAG_MOD);
      if (lsum >= DEPTH_U) begin
         lsum = lsum - DEPTH_U;
      end
      lidx = IW'(lsum);
      st_eff = (stall_ff == 3'(s_ff)) ? sstart_ff : now_ff;
      req_packed = {req_stick_y, req_stick_x, req_button};
      mem_raddr = ent_addr(sl, cidx_ff);
   end

   always_comb begin
      state_in = state_ff;
      cur_in = cur_ff;
      cidx_in = cidx_ff;
      mask_in = mask_ff;
      dfrom_in = dfrom_ff;
      stall_in = stall_ff;
      sstart_in = sstart_ff;
      lhost_in = lhost_ff;
      pc_in = pc_ff;
      ls_in = ls_ff;
      host_in = host_ff;
      dafter_in = dafter_ff;
      gafter_in = gafter_ff;
      s_in = s_ff;
      cslot_in = cslot_ff;
      cn_in = cn_ff;
      cci_in = cci_ff;
      now_in = now_ff;
      ok = 1'b0;
      rv_in = 1'b0;
      rkind_in = rkind_ff;
      rslot_in = rslot_ff;
      rframe_in = rframe_ff;
      rval_in = rval_ff;
      rnores_in = rnores_ff;
      rlast_in = rlast_ff;
      mem_we = 1'b0;
      mem_waddr = ent_addr(sl, cidx_ff);
      mem_wdata = {cur_ff, 32'd0};
      busy = (state_ff != ST_IDLE);

      if (csr_we) begin
         unique case (csr_index)
            REG_PLAYER_COUNT: pc_in = csr_wdata[2:0];
            REG_LOCAL_SLOT:   ls_in = csr_wdata[1:0];
            REG_IS_HOST:      host_in = csr_wdata[0];
            REG_DROP_AFTER:   dafter_in = csr_wdata;
            REG_GIVEUP_AFTER: gafter_in = csr_wdata;
            default: ;
         endcase
      end

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_waddr = ent_addr(cslot_ff, cci_ff);
            mem_wdata = {(cn_ff >= DEPTH_N) ? 32'(cn_ff - DEPTH_N) : 32'hFFFF_FFFF, 32'd0};
            if (cn_ff == CLR_LAST) begin
               cn_in = '0;
               cci_in = '0;
               cslot_in = cslot_ff + SW'(1);
               if (cslot_ff == SLOT_LAST) begin
                  state_in = ST_IDLE;
               end
            end else begin
               cn_in = cn_ff + NW'(1);
               cci_in = (cci_ff == IW'(RING_DEPTH - 1)) ? '0 : cci_ff + IW'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               rframe_in = cur_ff;
               rval_in = '0;
               rnores_in = 1'b0;
               rlast_in = 1'b1;
               rslot_in = req_slot;
               unique case (req_op)
                  OP_REMOTE: begin
                     if (req_host_msg && !host_ff) lhost_in = req_now_time;
                     ok = (4'(req_slot) < 4'(players)) && (req_slot != ls_ff) &&
                          !((req_frame + HALF) < cur_ff) && !(req_frame >= (cur_ff + HALF));
                     mem_we = ok;
                     mem_waddr = ent_addr(SW'(req_slot), ridx);
                     mem_wdata = {req_frame, req_packed};
                     rv_in = 1'b1;
                     rkind_in = ok ? KIND_ACCEPT : KIND_REJECT;
                  end
                  OP_LOCAL: begin
                     ok = 4'(ls_ff) < MAX_S4;
                     mem_we = ok;
                     mem_waddr = ent_addr(SW'(ls_ff), lidx);
                     mem_wdata = {cur_ff + LAG32, req_packed};
                     rv_in = 1'b1;
                     rkind_in = ok ? KIND_ACCEPT : KIND_REJECT;
                     rslot_in = ls_ff;
                  end
                  OP_DROP: begin
                     if (req_host_msg && !host_ff) lhost_in = req_now_time;
                     ok = !host_ff && req_host_msg && (req_slot != 2'd0) &&
                          (4'(req_slot) < MAX_S4) && !mask_ff[SW'(req_slot)];
                     if (ok) begin
                        mask_in[SW'(req_slot)] = 1'b1;
                        dfrom_in[SW'(req_slot)] = req_frame;
                     end
                     rv_in = 1'b1;
                     rkind_in = ok ? KIND_ACCEPT : KIND_REJECT;
                  end
                  OP_FRAME: begin
                     now_in = req_now_time;
                     s_in = '0;
                     if (players == '0) begin
                        stall_in = NO_STALL;
                        state_in = ST_PAD_RD;
                     end else begin
                        state_in = ST_CHK_RD;
                     end
                  end
                  default: ;
               endcase
            end
         end
         ST_CHK_RD: begin
            state_in = ST_CHK_EV;
         end
         ST_CHK_EV: begin
            ok = 1'b1;
            if (!(drop_now || tag == cur_ff)) begin
               if (4'(s_ff) == 4'(ls_ff)) begin
                  mem_we = 1'b1;
               end else begin
                  stall_in = 3'(s_ff);
                  sstart_in = st_eff;
                  if (host_ff && (now_ff - st_eff) >= dafter_ff) begin
                     mask_in[sl] = 1'b1;
                     dfrom_in[sl] = cur_ff;
                  end else if (!host_ff && (now_ff - lhost_ff) >= gafter_ff) begin
                     for (int o = 0; o < MAX_SLOTS; o++) begin
                        if (4'(o) < 4'(players) && 4'(o) != 4'(ls_ff) && !mask_ff[o]) begin
                           mask_in[o] = 1'b1;
                           dfrom_in[o] = cur_ff;
                        end
                     end
                  end else begin
                     ok = 1'b0;
                     rv_in = 1'b1;
                     rkind_in = KIND_STALL;
                     rslot_in = 2'(s_ff);
                     rframe_in = cur_ff;
                     rval_in = '0;
                     rnores_in = 1'b0;
                     rlast_in = 1'b1;
                     state_in = ST_IDLE;
                  end
               end
            end
            if (ok) begin
               if ((s_ff + CW'(1)) < players) begin
                  s_in = s_ff + CW'(1);
                  state_in = ST_CHK_RD;
               end else begin
                  s_in = '0;
                  stall_in = NO_STALL;
                  state_in = ST_PAD_RD;
               end
            end
         end
         ST_PAD_RD: begin
            state_in = ST_PAD_EV;
         end
         ST_PAD_EV: begin
            rv_in = 1'b1;
            rkind_in = KIND_PAD;
            rslot_in = 2'(s_ff);
            rframe_in = cur_ff;
            rval_in = ((s_ff < players) && !drop_now) ? mem_rdata[31:0] : 32'd0;
            rnores_in = !(s_ff < players);
            rlast_in = (s_ff == PAD_LAST);
            if (s_ff == PAD_LAST) begin
               cur_in = cur_ff + 32'd1;
               cidx_in = (cidx_ff == IW'(RING_DEPTH - 1)) ? '0 : cidx_ff + IW'(1);
               state_in = ST_IDLE;
            end else begin
               s_in = s_ff + CW'(1);
               state_in = ST_PAD_RD;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cur_ff <= '0;
         cidx_ff <= '0;
         mask_ff <= '0;
         for (int i = 0; i < MAX_SLOTS; i++) dfrom_ff[i] <= '0;
         stall_ff <= NO_STALL;
         sstart_ff <= '0;
         lhost_ff <= '0;
         pc_ff <= RST_PLAYER_COUNT;
         ls_ff <= '0;
         host_ff <= 1'b0;
         dafter_ff <= RST_DROP_AFTER;
         gafter_ff <= RST_GIVEUP_AFTER;
         s_ff <= '0;
         cslot_ff <= '0;
         cn_ff <= '0;
         cci_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cur_ff <= cur_in;
         cidx_ff <= cidx_in;
         mask_ff <= mask_in;
         dfrom_ff <= dfrom_in;
         stall_ff <= stall_in;
         sstart_ff <= sstart_in;
         lhost_ff <= lhost_in;
         pc_ff <= pc_in;
         ls_ff <= ls_in;
         host_ff <= host_in;
         dafter_ff <= dafter_in;
         gafter_ff <= gafter_in;
         s_ff <= s_in;
         cslot_ff <= cslot_in;
         cn_ff <= cn_in;
         cci_ff <= cci_in;
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      now_ff <= now_in;
      rkind_ff <= rkind_in;
      rslot_ff <= rslot_in;
      rframe_ff <= rframe_in;
      rval_ff <= rval_in;
      rnores_ff <= rnores_in;
      rlast_ff <= rlast_in;
   end

   assign rsp_valid = rv_ff;
   assign rsp_kind = rkind_ff;
   assign rsp_out_slot = rslot_ff;
   assign rsp_out_frame = rframe_ff;
   assign rsp_pad_button = rval_ff[15:0];
   assign rsp_pad_stick_x = $signed(rval_ff[23:16]);
   assign rsp_pad_stick_y = $signed(rval_ff[31:24]);
   assign rsp_no_response = rnores_ff;
   assign rsp_last = rlast_ff;

endmodule

@@ tb/tb_lockstep_input_frame_buffer.sv @@
// self-checking testbench for the lockstep input frame buffer
`timescale 1ns / 1ps

module tb_lockstep_input_frame_buffer;
   import lifb_pkg::*;

   typedef struct packed {
      logic [1:0]  op;
      logic [1:0]  slot;
      logic [31:0] frame;
      logic [15:0] button;
      logic [7:0]  stick_x;
      logic [7:0]  stick_y;
      logic        host_msg;
      logic [31:0] now_time;
   } pad_req_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  slot;
      logic [31:0] frame;
      logic [15:0] button;
      logic [7:0]  stick_x;
      logic [7:0]  stick_y;
      logic        no_response;
      logic        last;
   } pad_rsp_type;

   localparam int DEPTH = 128;
   localparam int LAG   = 2;
   localparam int SLOTS = 4;
   localparam int HALF  = DEPTH / 2;

   class frame_scoreboard;
      logic [31:0] ring_data [SLOTS][DEPTH];
      logic [31:0] ring_tag [SLOTS][DEPTH];
      logic [31:0] cur_frame;
      logic [3:0]  drop_mask;
      logic [31:0] drop_from [SLOTS];
      logic [2:0]  waiting_slot;
      logic [31:0] stall_since;
      logic [31:0] host_heard;
      logic [2:0]  player_count;
      logic [1:0]  local_slot;
      logic        is_host;
      logic [31:0] drop_after;
      logic [31:0] giveup_after;
      pad_rsp_type pending [$];
      int          errors;
      int          pads;
      int          stalls;
      int          rejects;

      function new();
         for (int s = 0; s < SLOTS; s++) begin
            drop_from[s] = 0;
            for (int i = 0; i < DEPTH; i++) begin
               ring_data[s][i] = 0;
               ring_tag[s][i] = (i < LAG) ? i : 32'hFFFF_FFFF;
            end
         end
         cur_frame = 0;
         drop_mask = 0;
         waiting_slot = NO_STALL;
         stall_since = 0;
         host_heard = 0;
         player_count = RST_PLAYER_COUNT;
         local_slot = 0;
         is_host = 0;
         drop_after = RST_DROP_AFTER;
         giveup_after = RST_GIVEUP_AFTER;
         errors = 0;
         pads = 0;
         stalls = 0;
         rejects = 0;
      endfunction

      function void set_reg(logic [2:0] idx, logic [31:0] val);
         case (idx)
            REG_PLAYER_COUNT: player_count = val[2:0];
            REG_LOCAL_SLOT:   local_slot = val[1:0];
            REG_IS_HOST:      is_host = val[0];
            REG_DROP_AFTER:   drop_after = val;
            REG_GIVEUP_AFTER: giveup_after = val;
            default: ;
         endcase
      endfunction

      function int active_players();
         return (player_count > SLOTS) ? SLOTS : player_count;
      endfunction

      function void store(int s, logic [31:0] f, logic [31:0] packed_pad);
         ring_data[s][f % DEPTH] = packed_pad;
         ring_tag[s][f % DEPTH] = f;
      endfunction

      function bit gone(int s, logic [31:0] f);
         return drop_mask[s] && f >= drop_from[s];
      endfunction

      function void add(logic [1:0] kind, logic [1:0] slot, logic [31:0] packed_pad,
                        logic nores, logic last);
         pad_rsp_type r;
         r.kind = kind;
         r.slot = slot;
         r.frame = cur_frame;
         r.button = packed_pad[15:0];
         r.stick_x = packed_pad[23:16];
         r.stick_y = packed_pad[31:24];
         r.no_response = nores;
         r.last = last;
         pending.push_back(r);
      endfunction

      function void note_input(pad_req_type r);
         logic [31:0] pp;
         int          players;
         bit          ok;
         bit          stalled;
         pp = {r.stick_y, r.stick_x, r.button};
         players = active_players();
         stalled = 0;
         case (r.op)
            OP_REMOTE: begin
               if (r.host_msg && !is_host) host_heard = r.now_time;
               ok = r.slot < players && r.slot != local_slot &&
                    !(r.frame + HALF < cur_frame) && !(r.frame >= cur_frame + HALF);
               if (ok) store(r.slot, r.frame, pp);
               else rejects++;
               add(ok ? KIND_ACCEPT : KIND_REJECT, r.slot, '0, 1'b0, 1'b1);
            end
            OP_LOCAL: begin
               store(local_slot, cur_frame + LAG, pp);
               add(KIND_ACCEPT, local_slot, '0, 1'b0, 1'b1);
            end
            OP_DROP: begin
               if (r.host_msg && !is_host) host_heard = r.now_time;
               ok = !is_host && r.host_msg && r.slot >= 1 && !drop_mask[r.slot];
               if (ok) begin
                  drop_mask[r.slot] = 1'b1;
                  drop_from[r.slot] = r.frame;
               end else begin
                  rejects++;
               end
               add(ok ? KIND_ACCEPT : KIND_REJECT, r.slot, '0, 1'b0, 1'b1);
            end
            default: begin
               for (int s = 0; s < players; s++) begin
                  if (gone(s, cur_frame) || ring_tag[s][cur_frame % DEPTH] == cur_frame)
                     continue;
                  if (s == local_slot) begin
                     store(s, cur_frame, '0);
                     continue;
                  end
                  if (waiting_slot != s) begin
                     waiting_slot = 3'(s);
                     stall_since = r.now_time;
                  end
                  if (is_host && r.now_time - stall_since >= drop_after) begin
                     drop_mask[s] = 1'b1;
                     drop_from[s] = cur_frame;
                     continue;
                  end
                  if (!is_host && r.now_time - host_heard >= giveup_after) begin
                     for (int o = 0; o < players; o++) begin
                        if (o != local_slot && !drop_mask[o]) begin
                           drop_mask[o] = 1'b1;
                           drop_from[o] = cur_frame;
                        end
                     end
                     continue;
                  end
                  add(KIND_STALL, 2'(s), '0, 1'b0, 1'b1);
                  stalls++;
                  stalled = 1;
                  break;
               end
               if (!stalled) begin
                  waiting_slot = NO_STALL;
                  for (int s = 0; s < SLOTS; s++) begin
                     pp = '0;
                     if (s < players && !gone(s, cur_frame)) pp = ring_data[s][cur_frame % DEPTH];
                     add(KIND_PAD, 2'(s), pp, s >= players, s == SLOTS - 1);
                     pads++;
                  end
                  cur_frame = cur_frame + 1;
               end
            end
         endcase
      endfunction

      function void compare(string name, logic [31:0] exp_v, logic [31:0] act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0h, got %0h", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(pad_rsp_type a);
         pad_rsp_type e;
         if (pending.size() == 0) begin
            $error("result with no transaction waiting: kind %0d slot %0d", a.kind, a.slot);
            errors++;
            return;
         end
         e = pending.pop_front();
         compare("kind", e.kind, a.kind);
         compare("out_slot", e.slot, a.slot);
         compare("out_frame", e.frame, a.frame);
         compare("pad_button", e.button, a.button);
         compare("pad_stick_x", e.stick_x, a.stick_x);
         compare("pad_stick_y", e.stick_y, a.stick_y);
         compare("no_response", e.no_response, a.no_response);
         compare("last", e.last, a.last);
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               start = 0;
   logic               busy;
   logic [1:0]         req_op = 0;
   logic [1:0]         req_slot = 0;
   logic [31:0]        req_frame = 0;
   logic [15:0]        req_button = 0;
   logic signed [7:0]  req_stick_x = 0;
   logic signed [7:0]  req_stick_y = 0;
   logic               req_host_msg = 0;
   logic [31:0]        req_now_time = 0;
   logic               rsp_valid;
   logic [1:0]         rsp_kind;
   logic [1:0]         rsp_out_slot;
   logic [31:0]        rsp_out_frame;
   logic [15:0]        rsp_pad_button;
   logic signed [7:0]  rsp_pad_stick_x;
   logic signed [7:0]  rsp_pad_stick_y;
   logic               rsp_no_response;
   logic               rsp_last;
   logic               csr_we = 0;
   logic [2:0]         csr_index = 0;
   logic [31:0]        csr_wdata = 0;

   frame_scoreboard sb = new();
   logic [31:0] wall_clock = 0;
   int          sent = 0;
   int          results = 0;
   int          quiet = 0;

   lockstep_input_frame_buffer dut (.*);

   always #10 clock = ~clock;

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         sb.check_result({rsp_kind, rsp_out_slot, rsp_out_frame, rsp_pad_button,
                          rsp_pad_stick_x, rsp_pad_stick_y, rsp_no_response, rsp_last});
         results++;
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || csr_we || (start && !busy)) quiet <= 0;
      else quiet <= quiet + 1;
      if (quiet >= 4000) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   task automatic write_reg(logic [2:0] idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      sb.set_reg(idx, val);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send(pad_req_type r);
      int gap;
      gap = $urandom_range(0, 4);
      if ($urandom_range(0, 3) == 0) gap = 0;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_op <= r.op;
      req_slot <= r.slot;
      req_frame <= r.frame;
      req_button <= r.button;
      req_stick_x <= r.stick_x;
      req_stick_y <= r.stick_y;
      req_host_msg <= r.host_msg;
      req_now_time <= r.now_time;
      start <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_input(r);
      sent++;
   endtask

   function automatic pad_req_type make_req(logic [1:0] op, logic [1:0] slot,
                                            logic [31:0] frame, logic host);
      pad_req_type r;
      r.op = op;
      r.slot = slot;
      r.frame = frame;
      r.button = 16'($urandom);
      r.stick_x = 8'($urandom);
      r.stick_y = 8'($urandom);
      r.host_msg = host;
      r.now_time = wall_clock;
      return r;
   endfunction

   task automatic tick_clock();
      if ($urandom_range(0, 11) == 0) wall_clock += $urandom_range(1000000, 20000000);
      else wall_clock += $urandom_range(0, 400000);
   endtask

   task automatic settle();
      start <= 1'b0;
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (24) @(posedge clock);
      while (busy) @(posedge clock);
   endtask

   task automatic play_rounds(int budget);
      int stop_at;
      int players;
      pad_req_type r;
      stop_at = sent + budget;
      while (sent < stop_at) begin
         players = sb.active_players();
         for (int s = 0; s < players; s++) begin
            if (s != sb.local_slot && $urandom_range(0, 99) < 85) begin
               tick_clock();
               send(make_req(OP_REMOTE, 2'(s), sb.cur_frame + $urandom_range(0, 3),
                             1'($urandom)));
            end
         end
         if ($urandom_range(0, 99) < 70) begin
            send(make_req(OP_LOCAL, 2'($urandom), $urandom, 1'($urandom)));
         end
         if ($urandom_range(0, 99) < 25) begin
            r = make_req(2'($urandom), 2'($urandom), $urandom, 1'($urandom));
            r.now_time = $urandom;
            send(r);
         end
         tick_clock();
         send(make_req(OP_FRAME, 2'($urandom), $urandom, 1'($urandom)));
      end
   endtask

   logic [2:0]  cfg_players [6] = '{3'd4, 3'd4, 3'd7, 3'd0, 3'd2, 3'd3};
   logic [1:0]  cfg_local [6]   = '{2'd1, 2'd0, 2'd3, 2'd2, 2'd1, 2'd0};
   logic        cfg_host [6]    = '{1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
   logic [31:0] cfg_drop [6]    = '{32'd0, 32'hFFFF_FFFF, 32'd5000000, 32'd3000000,
                                    32'hFFFF_FFFF, 32'd10000000};
   logic [31:0] cfg_giveup [6]  = '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'd1,
                                    32'd15000000, 32'd2000000};

   initial begin
      pad_req_type r;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // defaults: one player, client, local slot 0
      r = make_req(OP_LOCAL, 0, 0, 0);
      r.button = 16'hFFFF; r.stick_x = 8'h80; r.stick_y = 8'h7F;
      send(r);
      send(make_req(OP_FRAME, 0, 0, 0));
      send(make_req(OP_FRAME, 0, 0, 0));
      send(make_req(OP_REMOTE, 0, 1, 1));
      send(make_req(OP_REMOTE, 3, 1, 0));
      send(make_req(OP_DROP, 0, 0, 1));
      send(make_req(OP_DROP, 3, 32'hFFFF_FFFF, 0));
      send(make_req(OP_DROP, 3, 5, 1));
      send(make_req(OP_DROP, 3, 6, 1));
      send(make_req(OP_FRAME, 0, 0, 0));
      settle();

      // all players, client: window edges and the host silence timeout
      write_reg(REG_PLAYER_COUNT, 4);
      write_reg(REG_GIVEUP_AFTER, 32'd1000);
      send(make_req(OP_REMOTE, 1, sb.cur_frame + HALF - 1, 1));
      send(make_req(OP_REMOTE, 1, sb.cur_frame + HALF, 0));
      send(make_req(OP_REMOTE, 2, sb.cur_frame - HALF, 0));
      send(make_req(OP_REMOTE, 2, sb.cur_frame - HALF - 1, 0));
      send(make_req(OP_REMOTE, 1, sb.cur_frame, 1));
      send(make_req(OP_FRAME, 0, 0, 0));
      wall_clock += 32'd5000;
      send(make_req(OP_FRAME, 0, 0, 0));
      send(make_req(OP_FRAME, 0, 0, 0));
      settle();
      play_rounds(10);
      settle();

      for (int p = 0; p < 6; p++) begin
         write_reg(REG_PLAYER_COUNT, cfg_players[p]);
         write_reg(REG_LOCAL_SLOT, cfg_local[p]);
         write_reg(REG_IS_HOST, cfg_host[p]);
         write_reg(REG_DROP_AFTER, cfg_drop[p]);
         write_reg(REG_GIVEUP_AFTER, cfg_giveup[p]);
         play_rounds(12);
         settle();
      end

      $display("%0d transactions sent, %0d results checked: %0d pads, %0d stalls, %0d rejects",
               sent, results, sb.pads, sb.stalls, sb.rejects);
      $display("eight register settings covered, frame reached %0d", sb.cur_frame);
      if (sb.errors == 0 && sb.pending.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
